// ===== rtl/core/tcb_pkg.sv =====
// Shared types, constants and register codes of the tile map blitter.
package tcb_pkg;

    localparam int TILE_SIZE_DEF     = 8;
    localparam int TILESET_WORDS_DEF = 65536;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PIXEL_W     = 32;
    localparam int ID_W        = 16;
    localparam int COLS_W      = 9;
    localparam int GRID_W      = 10;
    localparam int DIM_W       = 12;
    localparam int SCROLL_W    = 16;
    localparam int POS_W       = 11;
    localparam int CALC_W      = 24;
    localparam int X_W         = 18;
    localparam int Y_W         = 14;
    localparam int DIV_STEPS   = 16;
    localparam int STEP_W      = 5;

    localparam logic [ID_W-1:0]     FIRST_GID_RST = 16'd1;
    localparam logic [COLS_W-1:0]   COLUMNS_RST   = 9'd32;
    localparam logic [DIM_W-1:0]    WIDTH_RST     = 12'd640;
    localparam logic [DIM_W-1:0]    HEIGHT_RST    = 12'd480;
    localparam logic [SCROLL_W-1:0] SCROLL_RST    = 16'd0;
    localparam logic [PIXEL_W-1:0]  KEY_RST       = 32'hFFFF00FF;
    localparam logic [DIM_W-1:0]    SCREEN_MAX    = 12'd2048;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FIRST_GID       = 3'd0,
        REG_TILESET_COLUMNS = 3'd1,
        REG_SCREEN_WIDTH    = 3'd2,
        REG_SCREEN_HEIGHT   = 3'd3,
        REG_SCROLL_X        = 3'd4,
        REG_COLOR_KEY       = 3'd5
    } cfg_index_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_DRAW = 1'b1
    } operation_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADDR,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic               valid;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [PIXEL_W-1:0] value;
    } hit_t;

endpackage

// ===== rtl/core/tcb_if.sv =====
// Handshake channels for tile items and pixel writes.
interface tcb_tile_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] load_address;
    logic [31:0] load_pixel;
    logic [15:0] tile_id;
    logic [9:0]  grid_col;
    logic [9:0]  grid_row;

    modport source (
        output valid, operation, load_address, load_pixel, tile_id, grid_col, grid_row,
        input  ready
    );
    modport sink (
        input  valid, operation, load_address, load_pixel, tile_id, grid_col, grid_row,
        output ready
    );
endinterface

interface tcb_write_if;
    logic        valid;
    logic        ready;
    logic [10:0] screen_x;
    logic [10:0] screen_y;
    logic [31:0] pixel_value;
    logic        last_write;

    modport source (
        output valid, screen_x, screen_y, pixel_value, last_write,
        input  ready
    );
    modport sink (
        input  valid, screen_x, screen_y, pixel_value, last_write,
        output ready
    );
endinterface

// ===== rtl/core/tcb_ram.sv =====
// Generic single-port RAM with registered read.
module tcb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tcb_div.sv =====
// Restoring divider, one quotient bit per cycle, returning the remainder.
module tcb_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tcb_pkg::ID_W-1:0]   dividend,
    input  logic [tcb_pkg::COLS_W-1:0] divisor,
    output logic                      done,
    output logic [tcb_pkg::COLS_W-1:0] remainder
);
    import tcb_pkg::*;

    logic [ID_W-1:0]   shift_reg;
    logic [COLS_W-1:0] rem_reg;
    logic [COLS_W-1:0] divisor_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [COLS_W:0]   trial;
    logic [COLS_W:0]   diff;
    logic              fits;

    assign trial = {rem_reg, shift_reg[ID_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};
    assign diff  = trial - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg   <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[ID_W-2:0], fits};
            rem_reg   <= fits ? diff[COLS_W-1:0] : trial[COLS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");

endmodule

// ===== rtl/core/tcb_emit.sv =====
// Holds the newest visible pixel until its last flag is known, then
// registers it onto the write channel.
module tcb_emit (
    input  logic          clk,
    input  logic          rst_n,
    input  tcb_pkg::hit_t hit,
    input  logic          flush,
    output logic          ready,
    tcb_write_if.source   writes
);
    import tcb_pkg::*;

    logic               pend_valid_reg;
    logic [POS_W-1:0]   pend_x_reg;
    logic [POS_W-1:0]   pend_y_reg;
    logic [PIXEL_W-1:0] pend_value_reg;
    logic               out_valid_reg;
    logic [POS_W-1:0]   out_x_reg;
    logic [POS_W-1:0]   out_y_reg;
    logic [PIXEL_W-1:0] out_value_reg;
    logic               out_last_reg;
    logic               out_free;
    logic               take;
    logic               move;

    assign out_free = !out_valid_reg || writes.ready;
    assign ready    = !pend_valid_reg || out_free;
    assign take     = hit.valid && ready;
    assign move     = pend_valid_reg && out_free && (hit.valid || flush);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (writes.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pend_x_reg     <= hit.x;
            pend_y_reg     <= hit.y;
            pend_value_reg <= hit.value;
        end
        if (move)
        begin
            out_x_reg     <= pend_x_reg;
            out_y_reg     <= pend_y_reg;
            out_value_reg <= pend_value_reg;
            out_last_reg  <= !take;
        end
    end

    assign writes.valid       = out_valid_reg;
    assign writes.screen_x    = out_x_reg;
    assign writes.screen_y    = out_y_reg;
    assign writes.pixel_value = out_value_reg;
    assign writes.last_write  = out_last_reg;

endmodule

// ===== rtl/core/tilemap_color_key_blitter_core.sv =====
// Tile map blitter top level: configuration, sequencer, scan and tileset store.
// A load is written to the store in the cycle it is accepted, and the block is ready again in the next cycle.
// A draw runs the divider, then the address and check states, then scans
// TILE_SIZE*TILE_SIZE pixels and drains; a tile beyond the store is skipped.
// The scan reads one pixel per cycle from the store port while writes are not stalled.
// Reset restores the register defaults; the tileset store stays undefined until loaded.
module tilemap_color_key_blitter_core #(
    parameter int TILE_SIZE     = tcb_pkg::TILE_SIZE_DEF,
    parameter int TILESET_WORDS = tcb_pkg::TILESET_WORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tcb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcb_pkg::CFG_DATA_W-1:0]  cfg_data,
    tcb_tile_if.sink                       tiles,
    tcb_write_if.source                    writes
);
    import tcb_pkg::*;

    localparam int AW   = $clog2(TILESET_WORDS);
    localparam int RC_W = $clog2(TILE_SIZE);
    localparam logic [RC_W-1:0] RC_LAST = RC_W'(TILE_SIZE - 1);

    logic [ID_W-1:0]            first_gid_reg;
    logic [COLS_W-1:0]          tileset_columns_reg;
    logic [DIM_W-1:0]           screen_width_reg;
    logic [DIM_W-1:0]           screen_height_reg;
    logic signed [SCROLL_W-1:0] scroll_x_reg;
    logic [PIXEL_W-1:0]         color_key_reg;

    state_t state_reg;
    state_t state_next;

    logic [ID_W-1:0]         local_reg;
    logic [GRID_W-1:0]       gcol_reg;
    logic [GRID_W-1:0]       grow_reg;
    logic [CALC_W-1:0]       base_reg;
    logic [CALC_W-1:0]       row_words_reg;
    logic [CALC_W-1:0]       row_addr_reg;
    logic signed [X_W-1:0]   x0_reg;
    logic [Y_W-1:0]          y0_reg;
    logic [RC_W-1:0]         r_reg;
    logic [RC_W-1:0]         c_reg;
    logic                    s1_act_reg;
    logic [POS_W-1:0]        s1_x_reg;
    logic [POS_W-1:0]        s1_y_reg;

    logic                    tile_fire;
    logic                    draw_ok;
    logic                    addr_ok;
    logic                    div_start;
    logic                    div_done;
    logic [COLS_W-1:0]       div_rem;
    logic [COLS_W-1:0]       cols_eff;
    logic [DIM_W-1:0]        w_clip;
    logic [DIM_W-1:0]        h_clip;
    logic [CALC_W-1:0]       load_idx;
    logic [CALC_W-1:0]       rd_addr;
    logic [CALC_W-1:0]       top_addr;
    logic                    top_over;
    logic signed [X_W-1:0]   px;
    logic [Y_W-1:0]          py;
    logic                    vis;
    logic                    last_pixel;
    logic                    scan_adv;
    logic                    flush;
    logic                    emit_ready;
    logic                    b_ok;
    logic                    ram_we;
    logic                    ram_re;
    logic [AW-1:0]           ram_addr;
    logic [PIXEL_W-1:0]      ram_rdata;
    hit_t                    hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_gid_reg       <= FIRST_GID_RST;
            tileset_columns_reg <= COLUMNS_RST;
            screen_width_reg    <= WIDTH_RST;
            screen_height_reg   <= HEIGHT_RST;
            scroll_x_reg        <= SCROLL_RST;
            color_key_reg       <= KEY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FIRST_GID:       first_gid_reg       <= cfg_data[ID_W-1:0];
                REG_TILESET_COLUMNS: tileset_columns_reg <= cfg_data[COLS_W-1:0];
                REG_SCREEN_WIDTH:    screen_width_reg    <= cfg_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT:   screen_height_reg   <= cfg_data[DIM_W-1:0];
                REG_SCROLL_X:        scroll_x_reg        <= cfg_data[SCROLL_W-1:0];
                REG_COLOR_KEY:       color_key_reg       <= cfg_data[PIXEL_W-1:0];
                default:             ;
            endcase
        end
    end

    assign cols_eff  = (tileset_columns_reg == '0) ? COLS_W'(1) : tileset_columns_reg;
    assign w_clip    = (screen_width_reg > SCREEN_MAX) ? SCREEN_MAX : screen_width_reg;
    assign h_clip    = (screen_height_reg > SCREEN_MAX) ? SCREEN_MAX : screen_height_reg;
    assign tile_fire = tiles.valid && tiles.ready;
    assign draw_ok   = (tiles.tile_id != '0) && (tiles.tile_id >= first_gid_reg);
    assign load_idx  = CALC_W'(tiles.load_address);
    assign addr_ok   = load_idx < CALC_W'(TILESET_WORDS);

    assign rd_addr    = row_addr_reg + CALC_W'(c_reg);
    assign top_addr   = base_reg + CALC_W'(TILE_SIZE - 1) * row_words_reg
                        + CALC_W'(TILE_SIZE - 1);
    assign top_over   = top_addr >= CALC_W'(TILESET_WORDS);
    assign px         = x0_reg + $signed(X_W'(c_reg));
    assign py         = y0_reg + Y_W'(r_reg);
    assign vis        = !px[X_W-1] && (px < $signed(X_W'(w_clip))) && (py < Y_W'(h_clip));
    assign last_pixel = (r_reg == RC_LAST) && (c_reg == RC_LAST);

    assign hit.valid = s1_act_reg && (ram_rdata != color_key_reg);
    assign hit.x     = s1_x_reg;
    assign hit.y     = s1_y_reg;
    assign hit.value = ram_rdata;
    assign b_ok      = !hit.valid || emit_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tile_fire && (tiles.operation == OP_DRAW) && draw_ok)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = top_over ? ST_IDLE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (b_ok && last_pixel)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_act_reg && emit_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        tiles.ready = 1'b0;
        div_start   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        scan_adv    = 1'b0;
        flush       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                tiles.ready = 1'b1;
                div_start   = tile_fire && (tiles.operation == OP_DRAW) && draw_ok;
                ram_we      = tile_fire && (tiles.operation == OP_LOAD) && addr_ok;
            end
            ST_SCAN:
            begin
                scan_adv = b_ok;
                ram_re   = b_ok;
            end
            ST_DRAIN:
            begin
                scan_adv = b_ok;
                flush    = !s1_act_reg;
            end
            default:
            begin
                tiles.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            s1_act_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (scan_adv)
            begin
                s1_act_reg <= (state_reg == ST_SCAN) && vis;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            local_reg <= tiles.tile_id - first_gid_reg;
            gcol_reg  <= tiles.grid_col;
            grow_reg  <= tiles.grid_row;
        end
        if (state_reg == ST_ADDR)
        begin
            base_reg      <= CALC_W'(TILE_SIZE * TILE_SIZE)
                             * CALC_W'(local_reg - ID_W'(div_rem))
                             + CALC_W'(TILE_SIZE) * CALC_W'(div_rem);
            row_words_reg <= CALC_W'(cols_eff) * CALC_W'(TILE_SIZE);
            x0_reg        <= $signed(X_W'(gcol_reg) * X_W'(TILE_SIZE))
                             + X_W'(scroll_x_reg);
            y0_reg        <= Y_W'(grow_reg) * Y_W'(TILE_SIZE);
        end
        if (state_reg == ST_CHECK)
        begin
            row_addr_reg <= base_reg;
            r_reg        <= '0;
            c_reg        <= '0;
        end
        else if ((state_reg == ST_SCAN) && scan_adv)
        begin
            s1_x_reg <= px[POS_W-1:0];
            s1_y_reg <= py[POS_W-1:0];
            if (c_reg == RC_LAST)
            begin
                c_reg        <= '0;
                r_reg        <= r_reg + RC_W'(1);
                row_addr_reg <= row_addr_reg + row_words_reg;
            end
            else
            begin
                c_reg <= c_reg + RC_W'(1);
            end
        end
    end

    assign ram_addr = (state_reg == ST_IDLE) ? load_idx[AW-1:0] : rd_addr[AW-1:0];

    tcb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (tiles.tile_id - first_gid_reg),
        .divisor   (cols_eff),
        .done      (div_done),
        .remainder (div_rem)
    );

    tcb_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (TILESET_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (tiles.load_pixel),
        .rdata (ram_rdata)
    );

    tcb_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .hit    (hit),
        .flush  (flush),
        .ready  (emit_ready),
        .writes (writes)
    );

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADDR) |-> (div_rem < cols_eff))
        else $error("remainder not below the column count");

    a_read_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (rd_addr < CALC_W'(TILESET_WORDS)))
        else $error("scan address beyond the tileset store");

    a_slot_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        s1_act_reg |-> ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)))
        else $error("pixel in flight outside a tile scan");

endmodule
